// ===== hw/rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_PAYLOAD,
    PH_DONE
  } wsd_phase_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_TRUNCATED = 2'd2
  } wsd_status_t;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] KEY_BYTES      = 4'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } wsd_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       payload_last;
    logic [1:0] frame_status;
  } wsd_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsd_stream_if.sv =====
// ----------------------------------------------------------------------------
// wsd_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// A word accepted into the input register passes the parser step into the
// result register (two register stages, input and result).
// Throughput: one byte per cycle while the result register is free to load.
// Reset: synchronous active-low rst_n returns the parser to the first header
// byte and empties both register stages.
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Frame deframer top: input register, parser step, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_core
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  wsd_stream_if.sink   in_if,
  wsd_stream_if.source out_if
);

  logic     s1_valid;
  wsd_in_t  s1_data;
  logic     out_free;
  logic     step;
  logic     res_valid;
  wsd_out_t res_data;

  assign step = s1_valid && out_free;

  wsd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_data  (in_if.data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_take  (step)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .s1_data   (s1_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  wsd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_data (res_data),
    .free      (out_free),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one accepted word until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  wsd_in_t in_data,
  output logic    s1_valid,
  output wsd_in_t s1_data,
  input  logic    s1_take
);

  logic    valid_r;
  wsd_in_t data_r;

  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (s1_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header/length/key state and per-byte unmasking.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  wsd_in_t  s1_data,
  output logic     res_valid,
  output wsd_out_t res_data
);

  wsd_phase_t             phase_r,  phase_nxt;
  logic                   masked_r, masked_nxt;
  logic [LENGTH_BITS-1:0] len_r,    len_nxt;
  logic [3:0]             hcnt_r,   hcnt_nxt;
  logic [7:0]             key_r [4];
  logic [7:0]             key_nxt [4];
  logic [LENGTH_BITS-1:0] rem_r,    rem_nxt;
  logic [1:0]             midx_r,   midx_nxt;

  logic [7:0]             b;
  logic                   ends;
  logic [LENGTH_BITS-1:0] len_shift;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [3:0]             cnt_inc;
  logic [3:0]             ext_limit;
  logic                   done_step;

  assign b         = s1_data.rx_byte;
  assign ends      = s1_data.buffer_end;
  assign rem_dec   = rem_r - LENGTH_BITS'(1);
  assign cnt_inc   = hcnt_r + 4'd1;
  assign ext_limit = (phase_r == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
  assign len_shift = (len_r[LENGTH_BITS-1 -: 8] != 8'd0) ? {LENGTH_BITS{1'b1}}
                                                        : {len_r[LENGTH_BITS-9:0], b};

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    hcnt_nxt   = hcnt_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    midx_nxt   = midx_r;
    unique case (phase_r)
      PH_HDR1: begin
        phase_nxt = PH_HDR2;
      end
      PH_HDR2: begin
        masked_nxt = b[7];
        hcnt_nxt   = 4'd0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT16;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT64;
        end else begin
          len_nxt = LENGTH_BITS'(b[6:0]);
          if (b[7]) begin
            phase_nxt = PH_KEY;
          end else begin
            rem_nxt   = LENGTH_BITS'(b[6:0]);
            midx_nxt  = 2'd0;
            phase_nxt = (b[6:0] == 7'd0) ? PH_DONE : PH_PAYLOAD;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt  = len_shift;
        hcnt_nxt = cnt_inc;
        if (cnt_inc >= ext_limit) begin
          hcnt_nxt = 4'd0;
          if (masked_r) begin
            phase_nxt = PH_KEY;
          end else begin
            rem_nxt   = len_shift;
            midx_nxt  = 2'd0;
            phase_nxt = (len_shift == '0) ? PH_DONE : PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        key_nxt[hcnt_r[1:0]] = b;
        hcnt_nxt = cnt_inc;
        if (cnt_inc >= KEY_BYTES) begin
          hcnt_nxt  = 4'd0;
          rem_nxt   = len_r;
          midx_nxt  = 2'd0;
          phase_nxt = (len_r == '0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        rem_nxt  = rem_dec;
        midx_nxt = midx_r + 2'd1;
        if (rem_dec == '0) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    done_step = (phase_nxt == PH_DONE);
    if (ends) begin
      phase_nxt  = PH_HDR1;
      masked_nxt = 1'b0;
      len_nxt    = '0;
      hcnt_nxt   = 4'd0;
      key_nxt    = '{default: 8'd0};
      rem_nxt    = '0;
      midx_nxt   = 2'd0;
    end
  end

  // result
  always_comb begin
    res_data = '0;
    if (phase_r == PH_PAYLOAD) begin
      res_data.payload_valid = 1'b1;
      res_data.payload_byte  = masked_r ? (b ^ key_r[midx_r]) : b;
      res_data.payload_last  = (rem_dec == '0);
    end
    if (ends) begin
      res_data.frame_status = done_step ? ST_COMPLETE : ST_TRUNCATED;
    end
    res_valid = res_data.payload_valid || ends;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR1;
      masked_r <= 1'b0;
      hcnt_r   <= 4'd0;
      midx_r   <= 2'd0;
      len_r    <= '0;
      rem_r    <= '0;
      key_r    <= '{default: 8'd0};
    end else if (step) begin
      phase_r  <= phase_nxt;
      masked_r <= masked_nxt;
      hcnt_r   <= hcnt_nxt;
      midx_r   <= midx_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  wsd_out_t load_data,
  output logic     free,
  output logic     out_valid,
  input  logic     out_ready,
  output wsd_out_t out_data
);

  logic     valid_r;
  wsd_out_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame deframer core. Byte buffers are streamed
// in (directed corner frames first, then random frames, cut buffers and
// noise), each accepted word is run through a local parser model, and every
// result word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import wsd_pkg::*;

  localparam int          LEN_BITS   = 64;
  localparam logic [63:0] LEN_LIMIT  = {64{1'b1}} >> (64 - LEN_BITS);
  localparam int          IDLE_PCT   = 11;
  localparam int          RAND_WORDS = 1350;
  localparam int          STALL_MAX  = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;
  logic steady = 1'b0;

  wsd_stream_if #(.T(wsd_in_t))  in_ch ();
  wsd_stream_if #(.T(wsd_out_t)) out_ch ();

  assign out_ch.ready = sink_ready;

  websocket_frame_deframer_core #(.LENGTH_BITS(LEN_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #4 clk = ~clk;

  // parser model state
  wsd_phase_t  ph;
  logic        masked_q;
  logic [63:0] len_acc;
  logic [3:0]  hdr_cnt;
  logic [7:0]  key_q [4];
  logic [63:0] remaining;
  logic [1:0]  key_idx;

  wsd_out_t expected_results [$];
  int       error_count = 0;
  int       words_sent = 0;
  int       results_seen = 0;
  int       stall_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t result %0d: %s", $realtime, results_seen, msg);
    error_count++;
  endtask

  task automatic clear_parser();
    ph        = PH_HDR1;
    masked_q  = 1'b0;
    len_acc   = '0;
    hdr_cnt   = '0;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    remaining = '0;
    key_idx   = '0;
  endtask

  task automatic begin_payload();
    remaining = len_acc;
    key_idx   = '0;
    ph        = (remaining == 0) ? PH_DONE : PH_PAYLOAD;
  endtask

  task automatic end_of_length();
    hdr_cnt = '0;
    if (masked_q) ph = PH_KEY;
    else begin_payload();
  endtask

  task automatic predict_word(input logic [7:0] b, input logic e);
    wsd_out_t r;
    r = '0;
    case (ph)
      PH_HDR1: ph = PH_HDR2;
      PH_HDR2: begin
        masked_q = b[7];
        len_acc  = {57'd0, b[6:0]};
        hdr_cnt  = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          len_acc = '0;
          ph      = PH_EXT16;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          len_acc = '0;
          ph      = PH_EXT64;
        end else begin
          end_of_length();
        end
      end
      PH_EXT16, PH_EXT64: begin
        if (len_acc > (LEN_LIMIT >> 8)) begin
          len_acc = LEN_LIMIT;
        end else begin
          len_acc = (len_acc << 8) | {56'd0, b};
          if (len_acc > LEN_LIMIT) len_acc = LEN_LIMIT;
        end
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= ((ph == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) end_of_length();
      end
      PH_KEY: begin
        key_q[hdr_cnt[1:0]] = b;
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= KEY_BYTES) begin
          hdr_cnt = '0;
          begin_payload();
        end
      end
      PH_PAYLOAD: begin
        r.payload_byte  = masked_q ? (b ^ key_q[key_idx]) : b;
        r.payload_valid = 1'b1;
        key_idx   = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        if (remaining == 0) begin
          r.payload_last = 1'b1;
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
    if (e) begin
      r.frame_status = (ph == PH_DONE) ? ST_COMPLETE : ST_TRUNCATED;
      clear_parser();
    end
    if (r.payload_valid || e) expected_results = {expected_results, r};
  endtask

  task automatic send_word(input logic [7:0] b, input logic e);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{rx_byte: b, buffer_end: e};
    do @(posedge clk); while (!in_ch.ready);
    predict_word(b, e);
    words_sent++;
  endtask

  task automatic send_buffer(ref logic [7:0] q [$]);
    for (int i = 0; i < q.size(); i++) send_word(q[i], i == q.size() - 1);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // header, optional key, then n_pay random payload bytes
  task automatic build_frame(ref logic [7:0] q [$], input logic m, input int form,
                             input logic [63:0] len, input int n_pay);
    q = {q, 8'($urandom)};
    case (form)
      0: q = {q, {m, len[6:0]}};
      1: begin
        q = {q, {m, LEN_CODE_EXT16}};
        q = {q, len[15:8]};
        q = {q, len[7:0]};
      end
      default: begin
        q = {q, {m, LEN_CODE_EXT64}};
        for (int i = 7; i >= 0; i--) q = {q, len[8*i +: 8]};
      end
    endcase
    if (m) for (int i = 0; i < 4; i++) q = {q, 8'($urandom)};
    for (int i = 0; i < n_pay; i++) q = {q, 8'($urandom)};
  endtask

  task automatic test_one_byte_buffer();
    logic [7:0] q [$];
    q = '{8'hFF};
    send_buffer(q);
  endtask

  task automatic test_empty_payload();
    logic [7:0] q [$];
    q = '{8'h81, 8'h00};
    send_buffer(q);
  endtask

  // masked, two payload bytes, one byte after the frame carries the end flag
  task automatic test_masked_with_trailing();
    logic [7:0] q [$];
    q = '{8'h82, 8'h82, 8'hA5, 8'h00, 8'hFF, 8'h3C, 8'h5A, 8'hFF, 8'h00};
    send_buffer(q);
  endtask

  // 16-bit length, buffer ends on the last payload byte
  task automatic test_ext16_end_on_last();
    logic [7:0] q [$];
    q = '{8'h01, 8'h7E, 8'h00, 8'h01, 8'h00};
    send_buffer(q);
  endtask

  // 64-bit all-ones length, buffer cut inside the key
  task automatic test_ext64_cut_in_key();
    logic [7:0] q [$];
    q = '{8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h12, 8'h34};
    send_buffer(q);
  endtask

  task automatic test_random_frames();
    logic [7:0]  q [$];
    int          kind;
    int          form;
    int          n_pay;
    int          frames;
    logic        m;
    logic [63:0] len;
    frames = 0;
    steady = 1'b1;
    while (words_sent < RAND_WORDS) begin
      if (words_sent > 330) steady = 1'b0;
      q.delete();
      kind = $urandom_range(0, 99);
      m    = 1'($urandom_range(0, 1));
      if (kind < 10) begin
        n_pay = $urandom_range(1, 10);
        for (int i = 0; i < n_pay; i++) q = {q, 8'($urandom)};
      end else begin
        form = $urandom_range(0, 2);
        case (form)
          0: len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                               : 64'($urandom_range(0, 12));
          1: len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 65535))
                                               : 64'($urandom_range(0, 24));
          default: len = ($urandom_range(0, 9) == 0) ? {32'($urandom), 32'($urandom)}
                                                     : 64'($urandom_range(0, 24));
        endcase
        n_pay = (len > 130) ? $urandom_range(0, 30) : int'(len);
        build_frame(q, m, form, len, n_pay);
        if (kind < 75) begin
          n_pay = $urandom_range(0, 3);
          for (int i = 0; i < n_pay; i++) q = {q, 8'($urandom)};
        end else if (q.size() > 1) begin
          q = q[0 : $urandom_range(0, q.size() - 2)];
        end
      end
      send_buffer(q);
      frames++;
      if (frames % 40 == 0) wait_for_results();
    end
  endtask

  always @(posedge clk) begin
    sink_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    wsd_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte exp %h got %h",
                                    want.payload_byte, out_ch.data.payload_byte));
        if (out_ch.data.payload_valid !== want.payload_valid)
          report_mismatch($sformatf("payload_valid exp %b got %b",
                                    want.payload_valid, out_ch.data.payload_valid));
        if (out_ch.data.payload_last !== want.payload_last)
          report_mismatch($sformatf("payload_last exp %b got %b",
                                    want.payload_last, out_ch.data.payload_last));
        if (out_ch.data.frame_status !== want.frame_status)
          report_mismatch($sformatf("frame_status exp %0d got %0d",
                                    want.frame_status, out_ch.data.frame_status));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("watchdog: no word moved for %0d cycles", STALL_MAX);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    clear_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_one_byte_buffer();
    test_empty_payload();
    test_masked_with_trailing();
    test_ext16_end_on_last();
    test_ext64_cut_in_key();
    test_random_frames();

    wait_for_results();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) report_mismatch("results still pending at end");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_stream_if.sv
hw/rtl/wsd_in_stage.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_out_stage.sv
hw/rtl/websocket_frame_deframer_core.sv
verif/testbench.sv
